FILE: rtl/assert_macros.svh
// Assertion helpers shared by the checker modules.
// The clock and reset of the enclosing module are named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion lbl failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion lbl failed");

// Condition that must hold in the cycle after reset is seen.
`define ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("assertion lbl failed");

`endif

FILE: rtl/csdm_pkg.sv
package csdm_pkg;

   localparam int ANG_FRAC = 20;
   localparam int QUO_W    = ANG_FRAC + 1;
   localparam int THETA_W  = ANG_FRAC + 3;
   localparam int Q30_W    = 31;
   localparam int CW       = 34;
   localparam int OUT_W    = 16;

   localparam logic [29:0] GAIN_INV = 30'd652032874;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sd16384;

   typedef enum logic [1:0] {
      REGION_EAST, REGION_NORTH, REGION_WEST, REGION_SOUTH
   } region_type;

   typedef enum logic [1:0] {
      QUAD_ZERO, QUAD_ONE, QUAD_TWO, QUAD_THREE
   } quarter_type;

   // One classified item handed from the front part to the back part.
   typedef struct packed {
      logic              origin;
      quarter_type       quad;
      logic [QUO_W-1:0]  resid;
      logic [Q30_W-1:0]  r_q30;
   } front_item_type;

   // Arctangent of 2^-i in radians, Q30, truncated.
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] a;
      case (idx)
         5'd0:  a = 30'h3243F6A8;
         5'd1:  a = 30'h1DAC6705;
         5'd2:  a = 30'h0FADBAFC;
         5'd3:  a = 30'h07F56EA6;
         5'd4:  a = 30'h03FEAB76;
         5'd5:  a = 30'h01FFD55B;
         5'd6:  a = 30'h00FFFAAA;
         5'd7:  a = 30'h007FFF55;
         5'd8:  a = 30'h003FFFEA;
         5'd9:  a = 30'h001FFFFD;
         5'd10: a = 30'h000FFFFF;
         5'd11: a = 30'h0007FFFF;
         5'd12: a = 30'h0003FFFF;
         5'd13: a = 30'h0001FFFF;
         5'd14: a = 30'h0000FFFF;
         5'd15: a = 30'h00007FFF;
         5'd16: a = 30'h00003FFF;
         5'd17: a = 30'h00001FFF;
         5'd18: a = 30'h00000FFF;
         5'd19: a = 30'h000007FF;
         5'd20: a = 30'h000003FF;
         5'd21: a = 30'h000001FF;
         5'd22: a = 30'h000000FF;
         5'd23: a = 30'h0000007F;
         5'd24: a = 30'h0000003F;
         5'd25: a = 30'h0000001F;
         5'd26: a = 30'h0000000F;
         5'd27: a = 30'h00000008;
         5'd28: a = 30'h00000004;
         5'd29: a = 30'h00000002;
         5'd30: a = 30'h00000001;
         default: a = 30'h00000000;
      endcase
      return a;
   endfunction

endpackage

FILE: rtl/csdm_if.sv
interface csdm_req_if #(parameter int FRAC_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS-1:0] u_first;
   logic [FRAC_BITS-1:0] u_second;
   modport source(output valid, u_first, u_second, input ready);
   modport sink(input valid, u_first, u_second, output ready);
endinterface

interface csdm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] disk_x;
   logic signed [15:0] disk_y;
   modport source(output valid, disk_x, disk_y, input ready);
   modport sink(input valid, disk_x, disk_y, output ready);
endinterface

FILE: rtl/csdm_front.sv
module csdm_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [FRAC_BITS-1:0]     u_first,
   input  logic [FRAC_BITS-1:0]     u_second,
   input  logic                     q_full,
   output logic                     q_push,
   output csdm_pkg::front_item_type q_item
);
   import csdm_pkg::*;

   localparam int F = FRAC_BITS;
   localparam logic [F+1:0] ONE = {2'b01, {F{1'b0}}};

   logic signed [F+1:0] sx, sy, ssum, r_full, minor;
   logic                origin, neg;
   region_type          region;
   logic                en;

   logic               vld_ff [0:QUO_W];
   logic               org_ff [0:QUO_W];
   logic               neg_ff [0:QUO_W];
   region_type         reg_ff [0:QUO_W];
   logic [F:0]         dvs_ff [0:QUO_W];
   logic [F+1:0]       rem_ff [0:QUO_W];
   logic [QUO_W-1:0]   quo_ff [0:QUO_W];

   logic [THETA_W-1:0] theta;
   logic [Q30_W-1:0]   r_q30;

   // Shift to [-1,1] and pick the wedge.
   always_comb begin
      sx     = $signed({1'b0, u_first, 1'b0}) - $signed(ONE);
      sy     = $signed({1'b0, u_second, 1'b0}) - $signed(ONE);
      ssum   = sx + sy;
      origin = (sx == '0) && (sy == '0);
      if (!ssum[F+1]) begin
         region = (sx > sy) ? REGION_EAST : REGION_NORTH;
      end else begin
         region = (sx <= sy) ? REGION_WEST : REGION_SOUTH;
      end
      unique case (region)
         REGION_EAST: begin
            r_full = sx;  minor = sy; neg = sy[F+1];
         end
         REGION_NORTH: begin
            r_full = sy;  minor = sx; neg = !sx[F+1] && (sx != '0);
         end
         REGION_WEST: begin
            r_full = -sx; minor = sy; neg = !sy[F+1] && (sy != '0);
         end
         default: begin
            r_full = -sy; minor = sx; neg = sx[F+1];
         end
      endcase
   end

   assign en       = !vld_ff[QUO_W] || !q_full;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         org_ff[0] <= origin;
         neg_ff[0] <= neg;
         reg_ff[0] <= region;
         dvs_ff[0] <= r_full[F:0];
         rem_ff[0] <= minor[F+1] ? -minor : minor;
         quo_ff[0] <= '0;
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [F+1:0] trial;
      logic         ge;
      always_comb begin
         trial = (j == 0) ? rem_ff[j] : {rem_ff[j][F:0], 1'b0};
         ge    = trial >= {1'b0, dvs_ff[j]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (en) begin
            vld_ff[j+1] <= vld_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            org_ff[j+1] <= org_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            reg_ff[j+1] <= reg_ff[j];
            dvs_ff[j+1] <= dvs_ff[j];
            rem_ff[j+1] <= ge ? trial - {1'b0, dvs_ff[j]} : trial;
            quo_ff[j+1] <= {quo_ff[j][QUO_W-2:0], ge};
         end
      end
   end

   // Angle in eighth-turns modulo eight: wedge offset plus or minus the quotient.
   always_comb begin
      theta = {reg_ff[QUO_W], {(THETA_W-2){1'b0}}}
            + (neg_ff[QUO_W] ? -THETA_W'(quo_ff[QUO_W]) : THETA_W'(quo_ff[QUO_W]));
   end

   if (F <= 30) begin : g_up
      assign r_q30 = Q30_W'(dvs_ff[QUO_W]) << (30 - F);
   end else begin : g_down
      assign r_q30 = Q30_W'(dvs_ff[QUO_W] >> (F - 30));
   end

   assign q_push        = vld_ff[QUO_W] && !q_full;
   assign q_item.origin = org_ff[QUO_W];
   assign q_item.quad   = quarter_type'(theta[THETA_W-1:THETA_W-2]);
   assign q_item.resid  = theta[QUO_W-1:0];
   assign q_item.r_q30  = r_q30;

endmodule

FILE: rtl/csdm_queue.sv
module csdm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  csdm_pkg::front_item_type push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output csdm_pkg::front_item_type head_item
);
   import csdm_pkg::*;

   logic           hv_ff, tv_ff;
   logic           hv_in, tv_in;
   front_item_type head_ff, tail_ff;

   // Two-entry queue; pop implies the head is valid, push implies not full.
   always_comb begin
      hv_in = hv_ff;
      tv_in = tv_ff;
      if (pop) begin
         hv_in = tv_ff || push;
         tv_in = 1'b0;
      end else if (push) begin
         hv_in = 1'b1;
         tv_in = hv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0;
         tv_ff <= 1'b0;
      end else begin
         hv_ff <= hv_in;
         tv_ff <= tv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         head_ff <= tv_ff ? tail_ff : push_item;
      end else if (push && !hv_ff) begin
         head_ff <= push_item;
      end
      if (push && hv_ff && !pop) begin
         tail_ff <= push_item;
      end
   end

   assign full       = tv_ff;
   assign head_valid = hv_ff;
   assign head_item  = head_ff;

endmodule

FILE: rtl/csdm_back.sv
module csdm_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  csdm_pkg::front_item_type head_item,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [15:0]       disk_x,
   output logic signed [15:0]       disk_y
);
   import csdm_pkg::*;

   localparam int NS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

   function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [CW-1:0] v);
      logic signed [CW:0]   s;
      logic signed [CW-16:0] t;
      logic signed [OUT_W-1:0] o;
      s = {v[CW-1], v} + (CW+1)'(32768);
      t = s[CW:16];
      if (t > (CW-15)'(OUT_MAX)) begin
         o = OUT_MAX;
      end else if (t < -(CW-15)'(OUT_MAX)) begin
         o = -OUT_MAX;
      end else begin
         o = t[OUT_W-1:0];
      end
      return o;
   endfunction

   logic en;
   logic [60:0] gain_prod;
   logic [50:0] ang_prod;

   logic               vld_ff [0:NS];
   logic               org_ff [0:NS];
   quarter_type        qd_ff  [0:NS];
   logic signed [CW-1:0] x_ff [0:NS];
   logic signed [CW-1:0] y_ff [0:NS];
   logic signed [CW-1:0] z_ff [0:NS];

   logic               ov_ff;
   logic signed [15:0] dx_ff, dy_ff;
   logic signed [CW-1:0] rx, ry;

   assign en  = !ov_ff || out_ready;
   assign pop = head_valid && en;

   always_comb begin
      gain_prod = 61'(head_item.r_q30) * 61'(GAIN_INV);
      ang_prod  = 51'(head_item.resid) * 51'(atan_q30(5'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         org_ff[0] <= head_item.origin;
         qd_ff[0]  <= head_item.quad;
         x_ff[0]   <= $signed({3'b000, gain_prod[60:30]});
         y_ff[0]   <= '0;
         z_ff[0]   <= $signed({3'b000, ang_prod[50:20]});
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      logic signed [CW-1:0] at;
      assign at = $signed({4'b0000, atan_q30(5'(i))});
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            org_ff[i+1] <= org_ff[i];
            qd_ff[i+1]  <= qd_ff[i];
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + at;
            end
         end
      end
   end

   // Exact quarter-turn rotation.
   always_comb begin
      unique case (qd_ff[NS])
         QUAD_ONE: begin
            rx = -y_ff[NS]; ry = x_ff[NS];
         end
         QUAD_TWO: begin
            rx = -x_ff[NS]; ry = -y_ff[NS];
         end
         QUAD_THREE: begin
            rx = y_ff[NS];  ry = -x_ff[NS];
         end
         default: begin
            rx = x_ff[NS];  ry = y_ff[NS];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= org_ff[NS] ? '0 : to_q14(rx);
         dy_ff <= org_ff[NS] ? '0 : to_q14(ry);
      end
   end

   assign out_valid = ov_ff;
   assign disk_x    = dx_ff;
   assign disk_y    = dy_ff;

endmodule

FILE: rtl/concentric_square_to_disk_map.sv
// Concentric square-to-disk mapping.
// The request channel carries two uniform fractions, u_first and u_second, each
// with INPUT_FRACTION_BITS fraction bits; the response channel returns one
// point disk_x, disk_y in two's complement with 14 fraction bits, within +-1.
// A request transfer and a response transfer both happen on a rising clock edge
// with valid and ready high. Every request gives exactly one response, in order.
// From request transfer to response valid an item passes one classify stage,
// 21 quotient stages, one queue stage, one scaling stage, CORDIC_STEPS
// rotation stages and the output register.
// Throughput is one pair per cycle unless the receiver stalls; the pipelined
// divider and the unrolled CORDIC each take one new item every unstalled cycle.
// Synchronous reset empties all stages and the queue; no response is valid in
// the cycle after reset. When the receiver stalls, the back part holds, the
// two-entry queue fills, and then the front part holds and drops req ready.
module concentric_square_to_disk_map #(
   parameter int INPUT_FRACTION_BITS = 16,
   parameter int CORDIC_STEPS        = 16
) (
   input logic        clock,
   input logic        reset,
   csdm_req_if.sink   req_bus,
   csdm_rsp_if.source rsp_bus
);
   import csdm_pkg::*;

   // Classified items go from the divider into the queue.
   logic           q_full, q_push, q_pop, q_head_valid;
   front_item_type q_item, q_head;

   // The front part shifts the inputs, picks the wedge and forms the angle
   // through a pipelined restoring divider.
   csdm_front #(
      .FRAC_BITS(INPUT_FRACTION_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .u_first  (req_bus.u_first),
      .u_second (req_bus.u_second),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_item)
   );

   // The queue lets the two parts stall on their own.
   csdm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head)
   );

   // The back part scales the radius, runs the CORDIC and rounds the result.
   csdm_back #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_item  (q_head),
      .pop        (q_pop),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .disk_x     (rsp_bus.disk_x),
      .disk_y     (rsp_bus.disk_y)
   );

endmodule

FILE: rtl/csdm_checker.sv
`include "assert_macros.svh"

module csdm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] disk_x,
   input logic signed [15:0] disk_y
);

   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(disk_x) && $stable(disk_y))
   `ASSERT_IMPLY(a_x_range, rsp_valid, disk_x <= 16'sd16384 && disk_x >= -16'sd16384)
   `ASSERT_IMPLY(a_y_range, rsp_valid, disk_y <= 16'sd16384 && disk_y >= -16'sd16384)
   `ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid)

endmodule

bind concentric_square_to_disk_map csdm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .disk_x    (rsp_bus.disk_x),
   .disk_y    (rsp_bus.disk_y)
);

FILE: bench/tb_concentric_square_to_disk_map.sv
module tb_concentric_square_to_disk_map;
   timeunit 1ns;
   timeprecision 1ps;

   import csdm_pkg::*;

   // Wait length used between test phases and to size the receiver hold-off.
   localparam int LATENCY     = 16 + 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 900;

   typedef struct packed {
      logic [15:0] u_first;
      logic [15:0] u_second;
   } pair_type;

   typedef struct packed {
      logic signed [15:0] disk_x;
      logic signed [15:0] disk_y;
   } point_type;

   logic clock;
   logic reset;

   csdm_req_if #(.FRAC_BITS(16)) req_bus ();
   csdm_rsp_if                   rsp_bus ();

   concentric_square_to_disk_map #(
      .INPUT_FRACTION_BITS(16),
      .CORDIC_STEPS(16)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // The stimulus process fills pending_pairs; the driver drains it.
   pair_type  pending_pairs[$];
   point_type expected_points[$];

   int  mismatch_count;
   int  unexpected_count;
   int  point_count;
   int  cycle_count;
   bit  steady_sender;    // When set, the driver never idles.
   bit  steady_receiver;  // When set, the receiver never idles.
   int  hold_off_cycles;  // Remaining cycles of a forced receiver stall.

   // Arctangent of 2^-i in radians, Q30, truncated; index 0 is pi/4.
   localparam logic [29:0] ARCTAN_Q30[32] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
      30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
      30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
      30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
      30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
      30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008,
      30'h00000004, 30'h00000002, 30'h00000001, 30'h00000000
   };

   // Signed quotient minor/radius with 20 fraction bits, truncated toward zero.
   function automatic longint signed_ratio(input longint minor, input longint radius);
      longint mag;
      longint q;
      if (radius <= 0) begin
         return 0;
      end
      mag = (minor < 0) ? -minor : minor;
      q = (mag <<< ANG_FRAC) / radius;
      return (minor < 0) ? -q : q;
   endfunction

   // Round Q30 to Q14 with floor((v + 2^15) / 2^16) and clamp to +-1.
   function automatic logic signed [15:0] round_to_q14(input longint v);
      longint o;
      o = (v + (64'sd1 <<< 15)) >>> 16;
      if (o > 16384) o = 16384;
      if (o < -16384) o = -16384;
      return o[15:0];
   endfunction

   // Map one square sample onto the disk, bit for bit as the block does.
   function automatic point_type map_to_disk(input pair_type p);
      point_type pt;
      longint sx, sy, radius, theta, resid, x, y, z, dx, dy, t;
      int quarter;
      sx = longint'(p.u_first) * 2 - 65536;
      sy = longint'(p.u_second) * 2 - 65536;
      if (sx == 0 && sy == 0) begin
         pt.disk_x = '0;
         pt.disk_y = '0;
         return pt;
      end
      if (sx >= -sy) begin
         if (sx > sy) begin
            radius = sx;
            theta = (sy > 0) ? signed_ratio(sy, radius)
                             : (64'sd8 <<< ANG_FRAC) + signed_ratio(sy, radius);
         end else begin
            radius = sy;
            theta = (64'sd2 <<< ANG_FRAC) - signed_ratio(sx, radius);
         end
      end else begin
         if (sx <= sy) begin
            radius = -sx;
            theta = (64'sd4 <<< ANG_FRAC) - signed_ratio(sy, radius);
         end else begin
            radius = -sy;
            theta = (64'sd6 <<< ANG_FRAC) + signed_ratio(sx, radius);
         end
      end
      // A full turn of eight eighth-turns wraps back to zero.
      theta = theta & ((64'sd8 <<< ANG_FRAC) - 1);
      quarter = int'((theta >>> (ANG_FRAC + 1)) & 3);
      resid = theta & ((64'sd2 <<< ANG_FRAC) - 1);
      z = (resid * longint'(ARCTAN_Q30[0])) >>> ANG_FRAC;
      radius = radius <<< 14;
      x = (radius * longint'(GAIN_INV)) >>> 30;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ARCTAN_Q30[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ARCTAN_Q30[i]);
         end
      end
      case (quarter)
         1: begin
            t = x; x = -y; y = t;
         end
         2: begin
            x = -x; y = -y;
         end
         3: begin
            t = x; x = y; y = -t;
         end
         default: ;
      endcase
      pt.disk_x = round_to_q14(x);
      pt.disk_y = round_to_q14(y);
      return pt;
   endfunction

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Driver: offers the head of the queue, idling on about 35 percent of its
   // chances unless a steady stretch runs. A valid that stays high for the next
   // item is assigned once per edge, so no lower-and-raise happens in one step.
   always @(posedge clock) begin
      pair_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.u_first <= '0;
         req_bus.u_second <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_points = {expected_points,
                               map_to_disk({req_bus.u_first, req_bus.u_second})};
            void'(pending_pairs.pop_front());
         end else if (req_bus.valid) begin
            // The current item stays on the bus until it is taken.
         end
         if (req_bus.valid && !req_bus.ready) begin
            req_bus.valid <= 1'b1;
         end else if (pending_pairs.size() > 0 &&
                      (steady_sender || $urandom_range(99) >= 35)) begin
            nxt = pending_pairs[0];
            req_bus.valid <= 1'b1;
            req_bus.u_first <= nxt.u_first;
            req_bus.u_second <= nxt.u_second;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver ready, with random stalls and a forced long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady_receiver || ($urandom_range(99) >= 35);
      end
   end

   // Monitor: every response transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         point_count <= point_count + 1;
         if (expected_points.size() == 0) begin
            unexpected_count <= unexpected_count + 1;
            if (mismatch_count + unexpected_count < 10) begin
               $display("unexpected response x=%0d y=%0d", rsp_bus.disk_x, rsp_bus.disk_y);
            end
         end else begin
            want = expected_points.pop_front();
            if (rsp_bus.disk_x !== want.disk_x || rsp_bus.disk_y !== want.disk_y) begin
               if (mismatch_count + unexpected_count < 10) begin
                  $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                           want.disk_x, want.disk_y, rsp_bus.disk_x, rsp_bus.disk_y);
               end
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("concentric_square_to_disk_map regression: fail");
         $finish;
      end
   end

   task automatic add_pair(input int a, input int b);
      pair_type p;
      p.u_first = a[15:0];
      p.u_second = b[15:0];
      pending_pairs = {pending_pairs, p};
   endtask

   task automatic wait_drained();
      while (pending_pairs.size() > 0 || req_bus.valid || expected_points.size() > 0) begin
         @(posedge clock);
      end
   endtask

   // Random pair: mostly uniform, some near the origin, the edges and the
   // diagonals so that region ties and wrap points are hit often.
   task automatic add_random_pair();
      int a, b, pick;
      pick = $urandom_range(9);
      a = $urandom_range(65535);
      b = $urandom_range(65535);
      case (pick)
         0: b = a;                                   // Main diagonal.
         1: b = 65536 - a;                           // Anti-diagonal.
         2: begin
            a = 32768 + $urandom_range(8) - 4;       // Close to the origin.
            b = 32768 + $urandom_range(8) - 4;
         end
         3: a = ($urandom_range(1)) ? 0 : 65535;     // Square edge.
         4: b = 32768;                               // Horizontal axis.
         default: ;
      endcase
      add_pair(a & 16'hFFFF, b & 16'hFFFF);
   endtask

   initial begin
      reset = 1'b1;
      steady_sender = 1'b0;
      steady_receiver = 1'b0;
      hold_off_cycles = 0;
      mismatch_count = 0;
      unexpected_count = 0;
      point_count = 0;
      cycle_count = 0;
      req_bus.valid = 1'b0;
      req_bus.u_first = '0;
      req_bus.u_second = '0;
      rsp_bus.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed corners: the exact origin, neighbors of the origin, the
      // four square corners, axis points, diagonal ties and the point just
      // below the positive x axis where the angle wraps past a full turn.
      add_pair(32768, 32768);
      add_pair(32769, 32768);
      add_pair(32768, 32769);
      add_pair(32767, 32768);
      add_pair(32768, 32767);
      add_pair(0, 0);
      add_pair(65535, 65535);
      add_pair(0, 65535);
      add_pair(65535, 0);
      add_pair(65535, 32768);
      add_pair(32768, 65535);
      add_pair(0, 32768);
      add_pair(32768, 0);
      add_pair(49152, 49152);
      add_pair(16384, 16384);
      add_pair(16384, 49152);
      add_pair(49152, 16384);
      add_pair(65535, 32767);
      add_pair(65535, 1);
      add_pair(1, 65535);
      add_pair(16'hAAAA, 16'h5555);
      add_pair(16'h5555, 16'hAAAA);
      wait_drained();

      // Sender pauses here after every expected point has arrived.
      repeat (LATENCY) @(posedge clock);

      // Back-pressure: the receiver holds off while the sender streams,
      // so the pipeline fills and request ready must drop.
      steady_sender = 1'b1;
      hold_off_cycles = 3 * LATENCY;
      repeat (150) add_random_pair();
      wait_drained();
      steady_sender = 1'b0;

      // Stretch with no idling on either side.
      steady_sender = 1'b1;
      steady_receiver = 1'b1;
      repeat (200) add_random_pair();
      wait_drained();
      steady_sender = 1'b0;
      steady_receiver = 1'b0;

      // Random idling on both sides for the rest.
      repeat (RANDOM_ITEMS - 350) add_random_pair();
      wait_drained();

      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d disk points: origin, corners, axis and diagonal ties,", point_count);
      $display("stalls, a long receiver hold-off and random pairs.");
      if (mismatch_count == 0 && unexpected_count == 0 && expected_points.size() == 0) begin
         $display("concentric_square_to_disk_map regression: pass");
      end else begin
         $display("%0d mismatches, %0d unexpected responses", mismatch_count, unexpected_count);
         $display("concentric_square_to_disk_map regression: fail");
      end
      $finish;
   end

endmodule
